// ===== rtl/shpl_pkg.sv =====
package shpl_pkg;

   // Table geometry and pointer width.
   localparam int TABLE_DEPTH   = 256;
   localparam int SLOT_W        = $clog2(TABLE_DEPTH);
   localparam int PTR_W         = 16;
   localparam int SIZE_W        = 4;
   localparam int SIZE_LOG2_MAX = SLOT_W;

   // Reset values of the control registers.
   localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = SIZE_W'(SIZE_LOG2_MAX);
   localparam logic [PTR_W-1:0]  NIL_VALUE_RESET = PTR_W'(2);

   // Request kinds.
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // Control register map: register i sits at byte address 4*i.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LOG2 = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NIL_VALUE = 1'b1;

   // Depth of the queue between the front and the back.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // One classified job as the back sees it. For a write, index is the slot
   // to write; for a lookup it is the hashed start slot.
   typedef struct packed {
      logic              lookup;
      logic [SLOT_W-1:0] index;
      logic [SLOT_W-1:0] mask;
      logic [PTR_W-1:0]  selector;
      logic [PTR_W-1:0]  method;
   } shpl_job_type;

endpackage

// ===== rtl/selector_hash_probe_lookup_core.sv =====
// Selector hash probe lookup: an open-addressing method dictionary with
// linear probing. A write word stores a selector and a method pointer in one
// slot and marks it occupied; a lookup word hashes its selector (shift right
// by one, masked to the 2^size_log2 slots in use, clamped to the 256-slot
// table) and probes slots one per cycle with wrap-around. The probe ends at
// an empty slot (never written, or holding nil_value) with a miss, at a
// matching selector with a hit that returns the slot and its method, or after
// one full wrap with a miss. Every request word produces exactly one response
// word, and writes and misses respond with all fields zero. In the back end a
// write goes straight to the result state and a lookup probes first; the slot
// store is a single-read-port memory with a registered read, so each probe
// step costs one memory read; the front end and a two-word queue keep
// accepting requests while the back end is busy or the response is stalled.
// Control registers (size_log2 at byte 0, nil_value at byte 4) are meant to be
// written only while the block is idle. The occupancy bits are flip-flops
// cleared by reset, so no clearing pass is needed after reset.
module selector_hash_probe_lookup_core import shpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,

   // Request channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [PTR_W-1:0]      req_selector,
   input  logic [PTR_W-1:0]      req_method_in,

   // Response channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [SLOT_W-1:0]     rsp_hit_slot,
   output logic [PTR_W-1:0]      rsp_method_out,

   // Control register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [SIZE_W-1:0]    size_log2_ff;
   logic [PTR_W-1:0]     nil_value_ff;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_we;

   logic                 push_valid;
   logic                 push_ready;
   shpl_job_type         push_job;
   logic                 pop_valid;
   logic                 pop_ready;
   shpl_job_type         pop_job;

   // The register file has two 32-bit registers, so address bit 2 picks one.
   assign csr_idx    = csr_paddr[2 +: CSR_IDX_W];
   assign csr_we     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= SIZE_LOG2_RESET;
         nil_value_ff <= NIL_VALUE_RESET;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_SIZE_LOG2: size_log2_ff <= csr_pwdata[SIZE_W-1:0];
            CSR_NIL_VALUE: nil_value_ff <= csr_pwdata[PTR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_SIZE_LOG2: csr_prdata = CSR_DATA_W'(size_log2_ff);
         CSR_NIL_VALUE: csr_prdata = CSR_DATA_W'(nil_value_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // The front end registers each request word and works out its slot:
   // the write slot, or the hashed start slot of a lookup.
   shpl_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_slot      (req_slot),
      .req_selector  (req_selector),
      .req_method_in (req_method_in),
      .size_log2     (size_log2_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_job      (push_job)
   );

   // A short queue decouples classification from the probe engine.
   shpl_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // The back end owns the slot store and the occupancy bits, runs the
   // probe, and holds the response word in an output register.
   shpl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (pop_valid),
      .job_ready      (pop_ready),
      .job            (pop_job),
      .nil_value      (nil_value_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_hit_slot   (rsp_hit_slot),
      .rsp_method_out (rsp_method_out)
   );

endmodule

// ===== rtl/shpl_ram.sv =====
module shpl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/shpl_front.sv =====
module shpl_front import shpl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [PTR_W-1:0]  req_selector,
   input  logic [PTR_W-1:0]  req_method_in,
   input  logic [SIZE_W-1:0] size_log2,
   output logic              push_valid,
   input  logic              push_ready,
   output shpl_job_type      push_job
);

   logic              front_valid_ff;
   shpl_job_type      job_ff;
   shpl_job_type      job_in;
   logic [SIZE_W-1:0] size_lg;
   logic [SLOT_W:0]   size_wide;
   logic [SLOT_W-1:0] mask;

   // Sizes beyond the table clamp to the whole table.
   always_comb begin
      size_lg   = (size_log2 > SIZE_W'(SIZE_LOG2_MAX)) ? SIZE_W'(SIZE_LOG2_MAX) : size_log2;
      size_wide = (SLOT_W + 1)'(1) << size_lg;
      mask      = SLOT_W'(size_wide - (SLOT_W + 1)'(1));

      job_in.lookup   = (req_type == REQ_LOOKUP);
      job_in.mask     = mask;
      job_in.selector = req_selector;
      job_in.method   = req_method_in;
      if (req_type == REQ_LOOKUP) begin
         job_in.index = SLOT_W'(req_selector >> 1) & mask;
      end else begin
         job_in.index = req_slot;
      end
   end

   assign req_ready  = !front_valid_ff || push_ready;
   assign push_valid = front_valid_ff;
   assign push_job   = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (req_ready) begin
         front_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         job_ff <= job_in;
      end
   end

endmodule

// ===== rtl/shpl_fifo.sv =====
module shpl_fifo import shpl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  shpl_job_type push_job,
   output logic         pop_valid,
   input  logic         pop_ready,
   output shpl_job_type pop_job
);

   shpl_job_type          entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/shpl_back.sv =====
module shpl_back import shpl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  shpl_job_type      job,
   input  logic [PTR_W-1:0]  nil_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [SLOT_W-1:0] rsp_hit_slot,
   output logic [PTR_W-1:0]  rsp_method_out
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_RESULT
   } state_type;

   state_type           state_ff;
   logic [TABLE_DEPTH-1:0] slot_valid_ff;
   logic [SLOT_W-1:0]   idx_ff;
   logic [SLOT_W-1:0]   mask_ff;
   logic [SLOT_W-1:0]   count_ff;
   logic [PTR_W-1:0]    sel_ff;
   logic                vbit_ff;
   logic                res_found_ff;
   logic [SLOT_W-1:0]   res_slot_ff;
   logic [PTR_W-1:0]    res_method_ff;
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [SLOT_W-1:0]   rsp_hit_slot_ff;
   logic [PTR_W-1:0]    rsp_method_out_ff;

   logic                ram_we;
   logic [SLOT_W-1:0]   ram_raddr;
   logic [2*PTR_W-1:0]  ram_rdata;
   logic [PTR_W-1:0]    rd_sel;
   logic [PTR_W-1:0]    rd_meth;
   logic [SLOT_W-1:0]   probe_next;
   logic                take_job;
   logic                out_free;

   shpl_ram #(
      .WIDTH (2 * PTR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (job.index),
      .wr_data ({job.selector, job.method}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign job_ready  = (state_ff == S_IDLE);
   assign take_job   = job_valid && job_ready;
   assign ram_we     = take_job && !job.lookup;
   assign probe_next = (idx_ff + 1'b1) & mask_ff;
   assign ram_raddr  = (state_ff == S_IDLE) ? job.index : probe_next;
   assign rd_sel     = ram_rdata[2*PTR_W-1:PTR_W];
   assign rd_meth    = ram_rdata[PTR_W-1:0];
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_hit_slot   = rsp_hit_slot_ff;
   assign rsp_method_out = rsp_method_out_ff;

   always_ff @(posedge clock) begin
      // The valid bit travels with the store read so both arrive together.
      vbit_ff <= slot_valid_ff[ram_raddr];
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
      end else begin
         // A word leaving while a new one is loaded is handled in S_RESULT.
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  res_found_ff  <= 1'b0;
                  res_slot_ff   <= '0;
                  res_method_ff <= '0;
                  if (job.lookup) begin
                     idx_ff   <= job.index;
                     mask_ff  <= job.mask;
                     sel_ff   <= job.selector;
                     count_ff <= '0;
                     state_ff <= S_CHECK;
                  end else begin
                     slot_valid_ff[job.index] <= 1'b1;
                     state_ff                 <= S_RESULT;
                  end
               end
            end
            S_CHECK: begin
               if (!vbit_ff || rd_sel == nil_value) begin
                  state_ff <= S_RESULT;
               end else if (rd_sel == sel_ff) begin
                  res_found_ff  <= 1'b1;
                  res_slot_ff   <= idx_ff;
                  res_method_ff <= rd_meth;
                  state_ff      <= S_RESULT;
               end else if (count_ff == mask_ff) begin
                  state_ff <= S_RESULT;
               end else begin
                  idx_ff   <= probe_next;
                  count_ff <= count_ff + 1'b1;
               end
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_found_ff      <= res_found_ff;
                  rsp_hit_slot_ff   <= res_slot_ff;
                  rsp_method_out_ff <= res_method_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // A miss or a write always reports an all-zero word.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_hit_slot_ff == '0 && rsp_method_out_ff == '0))
      else $error("miss word carries nonzero slot or method");

   // The probe never runs past one full wrap of the table in use.
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (count_ff <= mask_ff))
      else $error("probe count beyond table size");

   // A hit always lies inside the slots in use.
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && res_found_ff) |-> ((res_slot_ff & ~mask_ff) == '0))
      else $error("hit slot outside table in use");

   // A finished job leaves for the output as soon as the output is free.
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not moved to output");

endmodule
